/* hw/rtl/tbgs_pkg.sv */
// Shared constants, codes, command/status types and helpers for the ternary GEMV segment-sum block.
package tbgs_pkg;

   // Table sizes
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 8;
   localparam int MAX_BLOCKS  = 16;
   localparam int MAX_GROUPS  = 4096;
   localparam int MAX_SCATTER = 32768;

   localparam int PERM_DEPTH = MAX_BLOCKS * MAX_COLUMNS;
   localparam int OFFS_DEPTH = MAX_GROUPS + 1;
   localparam int PREF_DEPTH = MAX_COLUMNS + 1;

   // Address widths
   localparam int COL_AW  = $clog2(MAX_COLUMNS);
   localparam int PERM_AW = $clog2(PERM_DEPTH);
   localparam int GRP_AW  = $clog2(MAX_GROUPS);
   localparam int OFFS_AW = $clog2(OFFS_DEPTH);
   localparam int SCAT_AW = $clog2(MAX_SCATTER);
   localparam int PREF_AW = $clog2(PREF_DEPTH);

   // Field widths
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 15;
   localparam int ELEM_W = 32;
   localparam int WORD_W = 16;
   localparam int ROW_W  = 3;
   localparam int SGN_W  = 2;
   localparam int BLK_W  = 4;
   localparam int SUM_W  = 42;
   localparam int VLEN_W = 11;
   localparam int K_W    = 4;
   localparam int NB_W   = 5;
   localparam int PERM_W = 10;
   localparam int GE_W   = 11;
   localparam int GS_W   = 13;
   localparam int GCNT_W = 14;
   localparam int CSR_AW = 2;
   localparam int CSR_W  = 11;

   // Input commands
   localparam logic [CMD_W-1:0] CMD_VECTOR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PERM    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GEND    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_OFFSET  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCATTER = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GSTART  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 3'd6;

   // Register indexes
   localparam logic [CSR_AW-1:0] REG_VLEN   = 2'd0;
   localparam logic [CSR_AW-1:0] REG_ROWS   = 2'd1;
   localparam logic [CSR_AW-1:0] REG_BLOCKS = 2'd2;

   // Ternary sign codes
   localparam logic [SGN_W-1:0] SGN_ZERO = 2'b00;
   localparam logic [SGN_W-1:0] SGN_POS  = 2'b01;
   localparam logic [SGN_W-1:0] SGN_NEG2 = 2'b10;
   localparam logic [SGN_W-1:0] SGN_NEG  = 2'b11;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic begin_blk;
      logic pref;
      logic gs_start;
      logic gend_ld;
      logic sb_ld;
      logic grp_issue;
      logic grp_read;
      logic grp_agg;
      logic scat;
      logic out_first;
      logic out_next;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic blk_ok;
      logic pref_done;
      logic grp_more;
      logic scat_empty;
      logic scat_done;
      logic out_last;
   } sts_type;

   // Clamp a scatter offset to the table size
   function automatic logic [WORD_W-1:0] clamp_scat(input logic [WORD_W-1:0] v);
      logic [WORD_W-1:0] lim;
      lim = WORD_W'(MAX_SCATTER);
      return (v > lim) ? lim : v;
   endfunction

endpackage

/* hw/rtl/tbgs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tbgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/tbgs_ctrl.sv */
// Sequencer for loads, prefix build, group walk, scatter and row output.
module tbgs_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [tbgs_pkg::CMD_W-1:0]  req_command,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tbgs_pkg::cmd_type           cmd,
   input  tbgs_pkg::sts_type           sts
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREF = 4'd1;
   localparam logic [3:0] S_GS0  = 4'd2;
   localparam logic [3:0] S_GS1  = 4'd3;
   localparam logic [3:0] S_GS2  = 4'd4;
   localparam logic [3:0] S_SB   = 4'd5;
   localparam logic [3:0] S_GCHK = 4'd6;
   localparam logic [3:0] S_GRD  = 4'd7;
   localparam logic [3:0] S_PRD  = 4'd8;
   localparam logic [3:0] S_SCAT = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   logic [3:0] st_ff, st_in;
   logic       accept;

   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);
   assign accept    = req_valid && !req_stall;

   // Next state and datapath commands
   always_comb begin
      st_in = st_ff;
      cmd   = '0;
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_command == tbgs_pkg::CMD_COMPUTE) begin
                  if (sts.blk_ok) begin
                     cmd.begin_blk = 1'b1;
                     st_in         = S_PREF;
                  end
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_PREF: begin
            cmd.pref = 1'b1;
            if (sts.pref_done) begin
               st_in = S_GS0;
            end
         end
         S_GS0: st_in = S_GS1;
         S_GS1: begin
            cmd.gs_start = 1'b1;
            st_in        = S_GS2;
         end
         S_GS2: begin
            cmd.gend_ld = 1'b1;
            st_in       = S_SB;
         end
         S_SB: begin
            cmd.sb_ld = 1'b1;
            st_in     = S_GCHK;
         end
         S_GCHK: begin
            if (sts.grp_more) begin
               cmd.grp_issue = 1'b1;
               st_in         = S_GRD;
            end else begin
               cmd.out_first = 1'b1;
               st_in         = S_OUT;
            end
         end
         S_GRD: begin
            cmd.grp_read = 1'b1;
            st_in        = S_PRD;
         end
         S_PRD: begin
            cmd.grp_agg = 1'b1;
            st_in       = sts.scat_empty ? S_GCHK : S_SCAT;
         end
         S_SCAT: begin
            cmd.scat = 1'b1;
            if (sts.scat_done) begin
               st_in = S_GCHK;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (sts.out_last) begin
                  st_in = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   // No new word is taken while rows are being delivered
   a_out_blocks_in: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input accepted during row output");

   // A held row keeps the block in the output phase
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("row dropped while stalled");

   // After the final row is taken the block is idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && sts.out_last) |=> !req_stall)
      else $error("block not idle after final row");

endmodule

/* hw/rtl/tbgs_dp.sv */
// Datapath: config registers, table memories, prefix sums, group walk and row accumulators.
module tbgs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tbgs_pkg::CSR_AW-1:0]         csr_index,
   input  logic [tbgs_pkg::CSR_W-1:0]          csr_wdata,
   input  logic [tbgs_pkg::CMD_W-1:0]          req_command,
   input  logic [tbgs_pkg::IDX_W-1:0]          req_index,
   input  logic signed [tbgs_pkg::ELEM_W-1:0]  req_elem_value,
   input  logic [tbgs_pkg::WORD_W-1:0]         req_table_word,
   input  logic [tbgs_pkg::ROW_W-1:0]          req_target_row,
   input  logic signed [tbgs_pkg::SGN_W-1:0]   req_row_sign,
   input  logic [tbgs_pkg::BLK_W-1:0]          req_block_index,
   output logic [tbgs_pkg::BLK_W-1:0]          rsp_out_block,
   output logic [tbgs_pkg::ROW_W-1:0]          rsp_out_row,
   output logic signed [tbgs_pkg::SUM_W-1:0]   rsp_row_sum,
   output logic                                rsp_last,
   input  tbgs_pkg::cmd_type                   cmd,
   output tbgs_pkg::sts_type                   sts
);

   localparam int SW  = tbgs_pkg::SUM_W;
   localparam int VW  = tbgs_pkg::VLEN_W;
   localparam int GW  = tbgs_pkg::GCNT_W;
   localparam int OW  = tbgs_pkg::WORD_W;
   localparam int SCW = tbgs_pkg::ROW_W + tbgs_pkg::SGN_W;

   // Config registers and their saturated values
   logic [VW-1:0]              vlen_ff;
   logic [tbgs_pkg::K_W-1:0]   rows_ff;
   logic [tbgs_pkg::NB_W-1:0]  blks_ff;
   logic [VW-1:0]              n_sat;
   logic [tbgs_pkg::K_W-1:0]   k_sat;
   logic [tbgs_pkg::NB_W-1:0]  nb_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= VW'(tbgs_pkg::MAX_COLUMNS);
         rows_ff <= tbgs_pkg::K_W'(tbgs_pkg::MAX_ROWS);
         blks_ff <= tbgs_pkg::NB_W'(tbgs_pkg::MAX_BLOCKS);
      end else if (csr_we) begin
         unique case (csr_index)
            tbgs_pkg::REG_VLEN:   vlen_ff <= csr_wdata[VW-1:0];
            tbgs_pkg::REG_ROWS:   rows_ff <= csr_wdata[tbgs_pkg::K_W-1:0];
            tbgs_pkg::REG_BLOCKS: blks_ff <= csr_wdata[tbgs_pkg::NB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_sat  = (vlen_ff == '0) ? VW'(1) :
               (vlen_ff > VW'(tbgs_pkg::MAX_COLUMNS)) ? VW'(tbgs_pkg::MAX_COLUMNS) : vlen_ff;
      k_sat  = (rows_ff == '0) ? tbgs_pkg::K_W'(1) :
               (rows_ff > tbgs_pkg::K_W'(tbgs_pkg::MAX_ROWS)) ?
               tbgs_pkg::K_W'(tbgs_pkg::MAX_ROWS) : rows_ff;
      nb_sat = (blks_ff == '0) ? tbgs_pkg::NB_W'(1) :
               (blks_ff > tbgs_pkg::NB_W'(tbgs_pkg::MAX_BLOCKS)) ?
               tbgs_pkg::NB_W'(tbgs_pkg::MAX_BLOCKS) : blks_ff;
   end

   assign sts.blk_ok = ({1'b0, req_block_index} < nb_sat);

   function automatic logic [tbgs_pkg::IDX_W:0] IDX_LIM(input int d);
      return (tbgs_pkg::IDX_W + 1)'(d);
   endfunction

   // Load decode
   logic ld_vec, ld_perm, ld_ge, ld_so, ld_sc, ld_gs;
   assign ld_vec  = cmd.load && (req_command == tbgs_pkg::CMD_VECTOR)
                    && (req_index < IDX_LIM(tbgs_pkg::MAX_COLUMNS));
   assign ld_perm = cmd.load && (req_command == tbgs_pkg::CMD_PERM)
                    && (req_index < IDX_LIM(tbgs_pkg::PERM_DEPTH));
   assign ld_ge   = cmd.load && (req_command == tbgs_pkg::CMD_GEND)
                    && (req_index < IDX_LIM(tbgs_pkg::MAX_GROUPS));
   assign ld_so   = cmd.load && (req_command == tbgs_pkg::CMD_OFFSET)
                    && (req_index < IDX_LIM(tbgs_pkg::OFFS_DEPTH));
   assign ld_sc   = cmd.load && (req_command == tbgs_pkg::CMD_SCATTER)
                    && (req_index < IDX_LIM(tbgs_pkg::MAX_SCATTER));
   assign ld_gs   = cmd.load && (req_command == tbgs_pkg::CMD_GSTART);

   // Working registers
   logic [tbgs_pkg::BLK_W-1:0]   blk_ff;
   logic [tbgs_pkg::PERM_AW-1:0] base_ff;
   logic [VW-1:0]                icnt_ff, wcnt_ff;
   logic                         v1_ff, v2_ff;
   logic [SW-1:0]                run_ff;
   logic [GW-1:0]                g_ff, gend_ff;
   logic [OW-1:0]                sb_ff, se_ff, s_ff, slim_ff;
   logic [VW-1:0]                end_ff, start_ff;
   logic [SW-1:0]                pstart_ff, agg_ff;
   logic                         sv_ff;
   logic [SW-1:0]                acc_ff [tbgs_pkg::MAX_ROWS];
   logic [tbgs_pkg::ROW_W-1:0]   orow_ff;
   logic [SW-1:0]                osum_ff;
   logic                         olast_ff;

   // Memory ports
   logic [tbgs_pkg::ELEM_W-1:0]  vec_rdata;
   logic [tbgs_pkg::PERM_W-1:0]  perm_rdata;
   logic [tbgs_pkg::GE_W-1:0]    ge_rdata;
   logic [OW-1:0]                so_rdata;
   logic [SCW-1:0]               sc_rdata;
   logic [tbgs_pkg::GS_W-1:0]    gs_rdata;
   logic [SW-1:0]                pref_rdata;
   logic                         pref_we;
   logic [tbgs_pkg::PREF_AW-1:0] pref_waddr;
   logic [SW-1:0]                pref_wdata;
   logic [tbgs_pkg::OFFS_AW-1:0] so_raddr;
   logic [tbgs_pkg::BLK_W-1:0]   gs_raddr;
   logic [VW-1:0]                end_c;
   logic [SW-1:0]                vsum;
   logic                         issue, sissue;

   tbgs_ram #(.WIDTH(tbgs_pkg::ELEM_W), .DEPTH(tbgs_pkg::MAX_COLUMNS)) u_vec (
      .clock(clock), .we(ld_vec), .waddr(req_index[tbgs_pkg::COL_AW-1:0]),
      .wdata(req_elem_value), .raddr(perm_rdata[tbgs_pkg::COL_AW-1:0]), .rdata(vec_rdata));

   tbgs_ram #(.WIDTH(tbgs_pkg::PERM_W), .DEPTH(tbgs_pkg::PERM_DEPTH)) u_perm (
      .clock(clock), .we(ld_perm), .waddr(req_index[tbgs_pkg::PERM_AW-1:0]),
      .wdata(req_table_word[tbgs_pkg::PERM_W-1:0]),
      .raddr(tbgs_pkg::PERM_AW'(base_ff + tbgs_pkg::PERM_AW'(icnt_ff))),
      .rdata(perm_rdata));

   tbgs_ram #(.WIDTH(tbgs_pkg::GE_W), .DEPTH(tbgs_pkg::MAX_GROUPS)) u_ge (
      .clock(clock), .we(ld_ge), .waddr(req_index[tbgs_pkg::GRP_AW-1:0]),
      .wdata(req_table_word[tbgs_pkg::GE_W-1:0]),
      .raddr(g_ff[tbgs_pkg::GRP_AW-1:0]), .rdata(ge_rdata));

   tbgs_ram #(.WIDTH(OW), .DEPTH(tbgs_pkg::OFFS_DEPTH)) u_so (
      .clock(clock), .we(ld_so), .waddr(req_index[tbgs_pkg::OFFS_AW-1:0]),
      .wdata(req_table_word), .raddr(so_raddr), .rdata(so_rdata));

   tbgs_ram #(.WIDTH(SCW), .DEPTH(tbgs_pkg::MAX_SCATTER)) u_sc (
      .clock(clock), .we(ld_sc), .waddr(req_index[tbgs_pkg::SCAT_AW-1:0]),
      .wdata({req_target_row, req_row_sign}),
      .raddr(s_ff[tbgs_pkg::SCAT_AW-1:0]), .rdata(sc_rdata));

   tbgs_ram #(.WIDTH(tbgs_pkg::GS_W), .DEPTH(tbgs_pkg::MAX_BLOCKS)) u_gs (
      .clock(clock), .we(ld_gs), .waddr(req_block_index),
      .wdata(req_table_word[tbgs_pkg::GS_W-1:0]), .raddr(gs_raddr), .rdata(gs_rdata));

   tbgs_ram #(.WIDTH(SW), .DEPTH(tbgs_pkg::PREF_DEPTH)) u_pref (
      .clock(clock), .we(pref_we), .waddr(pref_waddr), .wdata(pref_wdata),
      .raddr(tbgs_pkg::PREF_AW'(end_c)), .rdata(pref_rdata));

   // Read address selection
   assign so_raddr = cmd.grp_issue ? tbgs_pkg::OFFS_AW'(g_ff + GW'(1))
                                   : g_ff[tbgs_pkg::OFFS_AW-1:0];
   assign gs_raddr = cmd.gs_start ? blk_ff + tbgs_pkg::BLK_W'(1) : blk_ff;
   assign end_c    = ({1'b0, ge_rdata} > {1'b0, n_sat}) ? n_sat : VW'(ge_rdata);

   // Prefix build: perm read, vector read, running sum
   assign issue = cmd.pref && (icnt_ff < n_sat);
   assign vsum  = run_ff + SW'(signed'(vec_rdata));

   always_comb begin
      pref_we    = cmd.begin_blk || v2_ff;
      pref_waddr = cmd.begin_blk ? '0 : tbgs_pkg::PREF_AW'(wcnt_ff + VW'(1));
      pref_wdata = cmd.begin_blk ? '0 : vsum;
   end

   assign sts.pref_done = (icnt_ff == n_sat) && !v1_ff && !v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_blk) begin
         blk_ff  <= req_block_index;
         base_ff <= tbgs_pkg::PERM_AW'(req_block_index * n_sat);
         icnt_ff <= '0;
         wcnt_ff <= '0;
         run_ff  <= '0;
      end else begin
         if (issue) begin
            icnt_ff <= icnt_ff + VW'(1);
         end
         if (v2_ff) begin
            run_ff  <= vsum;
            wcnt_ff <= wcnt_ff + VW'(1);
         end
      end
   end

   // Group walk registers
   assign sts.grp_more   = (g_ff < gend_ff) && (start_ff < n_sat)
                           && (g_ff < GW'(tbgs_pkg::MAX_GROUPS));
   assign sts.scat_empty = tbgs_pkg::clamp_scat(se_ff) <= tbgs_pkg::clamp_scat(sb_ff);

   always_ff @(posedge clock) begin
      if (cmd.begin_blk) begin
         start_ff  <= '0;
         pstart_ff <= '0;
      end
      if (cmd.gs_start) begin
         g_ff <= GW'(gs_rdata);
      end
      if (cmd.gend_ld) begin
         gend_ff <= (({1'b0, blk_ff} + tbgs_pkg::NB_W'(1)) < nb_sat) ? GW'(gs_rdata)
                    : g_ff + GW'(n_sat);
      end
      if (cmd.sb_ld) begin
         sb_ff <= so_rdata;
      end
      if (cmd.grp_read) begin
         end_ff <= end_c;
         se_ff  <= so_rdata;
      end
      if (cmd.grp_agg) begin
         agg_ff    <= (end_ff > start_ff) ? pref_rdata - pstart_ff : '0;
         pstart_ff <= pref_rdata;
         start_ff  <= end_ff;
         s_ff      <= tbgs_pkg::clamp_scat(sb_ff);
         slim_ff   <= tbgs_pkg::clamp_scat(se_ff);
         sb_ff     <= se_ff;
         g_ff      <= g_ff + GW'(1);
      end else if (sissue) begin
         s_ff <= s_ff + OW'(1);
      end
   end

   // Scatter: one entry per cycle into the row accumulators
   logic [tbgs_pkg::ROW_W-1:0] sc_row;
   logic [tbgs_pkg::SGN_W-1:0] sc_sgn;
   logic [SW-1:0]              term;

   assign sissue        = cmd.scat && (s_ff < slim_ff);
   assign sts.scat_done = (s_ff >= slim_ff) && !sv_ff;
   assign sc_row        = sc_rdata[SCW-1:tbgs_pkg::SGN_W];
   assign sc_sgn        = sc_rdata[tbgs_pkg::SGN_W-1:0];

   always_comb begin
      unique case (sc_sgn)
         tbgs_pkg::SGN_POS:  term = agg_ff;
         tbgs_pkg::SGN_NEG:  term = SW'(0) - agg_ff;
         tbgs_pkg::SGN_NEG2: term = SW'(0) - {agg_ff[SW-2:0], 1'b0};
         tbgs_pkg::SGN_ZERO: term = '0;
         default:            term = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= sissue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_blk) begin
         for (int r = 0; r < tbgs_pkg::MAX_ROWS; r++) begin
            acc_ff[r] <= '0;
         end
      end else if (sv_ff && ({1'b0, sc_row} < k_sat)) begin
         acc_ff[sc_row] <= acc_ff[sc_row] + term;
      end
   end

   // Result word register
   assign sts.out_last = olast_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_first) begin
         orow_ff  <= '0;
         osum_ff  <= acc_ff[0];
         olast_ff <= (k_sat == tbgs_pkg::K_W'(1));
      end else if (cmd.out_next) begin
         orow_ff  <= orow_ff + tbgs_pkg::ROW_W'(1);
         osum_ff  <= acc_ff[orow_ff + tbgs_pkg::ROW_W'(1)];
         olast_ff <= (({1'b0, orow_ff} + tbgs_pkg::K_W'(2)) == k_sat);
      end
   end

   assign rsp_out_block = blk_ff;
   assign rsp_out_row   = orow_ff;
   assign rsp_row_sum   = osum_ff;
   assign rsp_last      = olast_ff;

endmodule

/* hw/rtl/ternary_block_gemv_segment_sum_core.sv */
// Top level of the ternary block GEMV segment-sum engine.
// Usage:
//   The req channel carries one word per item: table loads (vector element,
//   permutation entry, group end, scatter offset, scatter row/sign entry,
//   block group start) or a compute command for one block.
//   Loads are accepted back to back while idle and return nothing; out-of-range loads are dropped.
//   A compute command for a block below block_count returns one rsp word per
//   row of the block (rows_per_block words), last set on the final row.
//   Compute steps: build the prefix sums (perm read, vector read, add
//   pipeline), fetch the group bounds, then for each group read its bounds and
//   aggregate, and scatter its entries into the row accumulators when its scatter
//   range is not empty, then deliver the rows from the output register.
//   The group walk is bound by the single read port of each table memory.
//   req_stall stays high from compute acceptance until the last row is taken.
//   A stalled rsp word holds; the block waits in the output phase.
//   Reset (synchronous) returns the controller to idle and the csr registers
//   to n = 1024, k = 8, 16 blocks; table memories hold garbage until loaded.
//   csr writes are taken in any cycle but are meant for idle periods only.
module ternary_block_gemv_segment_sum_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [tbgs_pkg::CSR_AW-1:0]         csr_index,
   input  logic [tbgs_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tbgs_pkg::CMD_W-1:0]          req_command,
   input  logic [tbgs_pkg::IDX_W-1:0]          req_index,
   input  logic signed [tbgs_pkg::ELEM_W-1:0]  req_elem_value,
   input  logic [tbgs_pkg::WORD_W-1:0]         req_table_word,
   input  logic [tbgs_pkg::ROW_W-1:0]          req_target_row,
   input  logic signed [tbgs_pkg::SGN_W-1:0]   req_row_sign,
   input  logic [tbgs_pkg::BLK_W-1:0]          req_block_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbgs_pkg::BLK_W-1:0]          rsp_out_block,
   output logic [tbgs_pkg::ROW_W-1:0]          rsp_out_row,
   output logic signed [tbgs_pkg::SUM_W-1:0]   rsp_row_sum,
   output logic                                rsp_last
);

   tbgs_pkg::cmd_type cmd;
   tbgs_pkg::sts_type sts;

   tbgs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .cmd         (cmd),
      .sts         (sts)
   );

   tbgs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req_command),
      .req_index       (req_index),
      .req_elem_value  (req_elem_value),
      .req_table_word  (req_table_word),
      .req_target_row  (req_target_row),
      .req_row_sign    (req_row_sign),
      .req_block_index (req_block_index),
      .rsp_out_block   (rsp_out_block),
      .rsp_out_row     (rsp_out_row),
      .rsp_row_sum     (rsp_row_sum),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .sts             (sts)
   );

endmodule
